// ===== rtl/touch_gesture_classifier_top_defines.svh =====
// Assertion macros shared by the gesture classifier RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tgc_pkg.sv =====
// Package for the touch gesture classifier: beat types, configuration types and codes.
// It has no dependencies. Every module of the block imports it.
package tgc_pkg;

    localparam int COORD_W    = 9;
    localparam int TIME_W     = 32;
    localparam int MS_CFG_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_DISTANCE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COLUMN    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [MS_CFG_W-1:0] RST_LONG_PRESS_TIME = 16'd600;
    localparam logic [MS_CFG_W-1:0] RST_TAP_MAX_TIME    = 16'd300;
    localparam logic [COORD_W-1:0]  RST_SWIPE_DISTANCE  = 9'd60;
    localparam logic [COORD_W-1:0]  RST_SPLIT_COLUMN    = 9'd240;

    typedef enum logic [2:0] {
        G_NONE        = 3'd0,
        G_TAP         = 3'd1,
        G_SWIPE_LEFT  = 3'd2,
        G_SWIPE_RIGHT = 3'd3,
        G_LONG_LEFT   = 3'd4,
        G_LONG_RIGHT  = 3'd5
    } t_gesture;

    typedef struct packed {
        logic               touch_active;
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic [TIME_W-1:0]  now_ms;
    } t_in_beat;

    typedef struct packed {
        t_gesture           gesture;
        logic [COORD_W-1:0] event_x;
        logic [COORD_W-1:0] event_y;
    } t_out_beat;

    typedef struct packed {
        logic [MS_CFG_W-1:0] long_press_time;
        logic [MS_CFG_W-1:0] tap_max_time;
        logic [COORD_W-1:0]  swipe_distance;
        logic [COORD_W-1:0]  split_column;
    } t_cfg;

endpackage

// ===== rtl/tgc_cfg.sv =====
// Configuration register file of the touch gesture classifier.
// Depends on tgc_pkg for the register indexes, reset values and the t_cfg struct.
module tgc_cfg
    import tgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Write one register per enabled cycle; the narrow ones take the low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_time <= RST_LONG_PRESS_TIME;
            r_cfg.tap_max_time    <= RST_TAP_MAX_TIME;
            r_cfg.swipe_distance  <= RST_SWIPE_DISTANCE;
            r_cfg.split_column    <= RST_SPLIT_COLUMN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS_TIME: r_cfg.long_press_time <= i_cfg_data[MS_CFG_W-1:0];
                CFG_TAP_MAX_TIME:    r_cfg.tap_max_time    <= i_cfg_data[MS_CFG_W-1:0];
                CFG_SWIPE_DISTANCE:  r_cfg.swipe_distance  <= i_cfg_data[COORD_W-1:0];
                CFG_SPLIT_COLUMN:    r_cfg.split_column    <= i_cfg_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/tgc_classify.sv =====
// Press tracking state and gesture decision for one poll of the touch panel.
// Depends on tgc_pkg for the beat types, the gesture codes and the t_cfg struct.
module tgc_classify
    import tgc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_beat  i_beat,
    input  t_cfg      i_cfg,
    output t_out_beat o_result
);

    logic               r_is_pressed;
    logic               r_long_reported;
    logic [COORD_W-1:0] r_start_x;
    logic [COORD_W-1:0] r_start_y;
    logic [COORD_W-1:0] r_last_x;
    logic [TIME_W-1:0]  r_press_time;

    logic               n_is_pressed;
    logic               n_long_reported;

    logic               new_press;
    logic               held;
    logic               release_evt;
    logic [COORD_W-1:0] cur_x;
    logic               leftward;
    logic [COORD_W-1:0] span;
    logic [TIME_W-1:0]  dur;
    logic               small_travel;
    logic               long_due;
    logic               tap_due;
    t_gesture           gesture;

    assign new_press   = i_beat.touch_active && !r_is_pressed;
    assign held        = i_beat.touch_active && r_is_pressed;
    assign release_evt = !i_beat.touch_active && r_is_pressed;

    // Travel is measured to the current x while held, to the last seen x on release.
    assign cur_x        = i_beat.touch_active ? i_beat.touch_x : r_last_x;
    assign leftward     = cur_x < r_start_x;
    assign span         = leftward ? (r_start_x - cur_x) : (cur_x - r_start_x);
    assign small_travel = span < i_cfg.swipe_distance;

    // Elapsed time wraps with the free running millisecond counter.
    assign dur      = i_beat.now_ms - r_press_time;
    assign long_due = dur >= {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.long_press_time};
    assign tap_due  = dur <= {{(TIME_W-MS_CFG_W){1'b0}}, i_cfg.tap_max_time};

    // Gesture decision and the next press flags.
    always_comb begin
        gesture         = G_NONE;
        n_is_pressed    = r_is_pressed;
        n_long_reported = r_long_reported;
        if (new_press) begin
            n_is_pressed    = 1'b1;
            n_long_reported = 1'b0;
        end else if (held) begin
            if (!r_long_reported && long_due && small_travel) begin
                n_long_reported = 1'b1;
                gesture = (r_start_x < i_cfg.split_column) ? G_LONG_LEFT : G_LONG_RIGHT;
            end
        end else if (release_evt) begin
            n_is_pressed = 1'b0;
            if (!r_long_reported) begin
                if (tap_due && small_travel) begin
                    gesture = G_TAP;
                end else if (!small_travel) begin
                    gesture = leftward ? G_SWIPE_LEFT : G_SWIPE_RIGHT;
                end
            end
        end
    end

    // Press flags are control state and are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pressed    <= 1'b0;
            r_long_reported <= 1'b0;
        end else if (i_step) begin
            r_is_pressed    <= n_is_pressed;
            r_long_reported <= n_long_reported;
        end
    end

    // Start point, start time and latest x are only read while a press is open.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (new_press) begin
                r_start_x    <= i_beat.touch_x;
                r_start_y    <= i_beat.touch_y;
                r_press_time <= i_beat.now_ms;
            end
            if (i_beat.touch_active) begin
                r_last_x <= i_beat.touch_x;
            end
        end
    end

    assign o_result.gesture = gesture;
    assign o_result.event_x = (gesture != G_NONE) ? r_start_x : '0;
    assign o_result.event_y = (gesture != G_NONE) ? r_start_y : '0;

endmodule

// ===== rtl/touch_gesture_classifier_top.sv =====
// Top level of the touch gesture classifier: input register, classifier, result register.
// Depends on tgc_pkg, tgc_cfg, tgc_classify and touch_gesture_classifier_top_defines.svh.
//
// Use of the block:
//   Input channel: one beat per touch poll (touch flag, x, y, millisecond time),
//   taken at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: exactly one result beat per poll (gesture, start x, start y),
//   taken at a clock edge with o_out_valid high and i_out_stall low.
//   An accepted poll waits in the input register, is classified on its way into the
//   result register and is presented from there until it is taken.
//   Throughput: one poll per cycle unless the receiver stalls; the decision is a 32-bit
//   subtract, two 32-bit compares and three 9-bit compares between the input and result registers.
//   When the receiver stalls, the result register holds; the input register still
//   takes one more poll, and then o_in_stall rises until the result moves on.
//   Reset (synchronous, active low) empties both registers, ends any open press
//   and loads the default thresholds: 600 ms long press, 300 ms tap, 60 pixel
//   swipe, split at column 240.
//   Configuration writes take effect on the next cycle and must be made while idle.
`include "touch_gesture_classifier_top_defines.svh"

module touch_gesture_classifier_top
    import tgc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    t_cfg      cfg;
    t_out_beat result;
    logic      out_free;
    logic      step;
    logic      in_take;

    // The result register can load when empty or when its beat leaves this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    tgc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tgc_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (r_in_beat),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // A poll moved into the classifier always leaves a result behind.
    `TGC_ASSERT_NEXT(a_step_fills_out, step, r_out_valid, "poll lost before the result register")

    // A waiting poll stays in the input register until it is classified.
    `TGC_ASSERT_NEXT(a_in_held, r_in_valid && !step, r_in_valid, "waiting poll dropped")

    // Back-pressure on the input only comes from a full pipeline.
    `TGC_ASSERT_SAME(a_stall_full, o_in_stall, r_in_valid && r_out_valid && i_out_stall,
        "input stalled with room in the pipeline")

    // A result without a gesture carries a zero start point.
    `TGC_ASSERT_SAME(a_none_zero, r_out_valid && (r_out_beat.gesture == G_NONE),
        (r_out_beat.event_x == '0) && (r_out_beat.event_y == '0),
        "empty gesture with a non-zero point")

endmodule
